// File: rtl/bpc_pkg.sv
// Shared types, codes and constants of the button press classifier.
package bpc_pkg;

    // Field widths of the transaction payloads
    localparam int OPCODE_W = 3;
    localparam int PIN_W    = 4;
    localparam int IDX_W    = 3;
    localparam int CLASS_W  = 2;
    localparam int THR_W    = 16;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Defaults handed to the top-level parameters
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int COUNT_BITS_DEF  = 16;

    // Threshold values after reset
    localparam logic [THR_W-1:0] LONG_THR_RST  = 16'd100;
    localparam logic [THR_W-1:0] SHORT_THR_RST = 16'd5;

    // Operation codes; the two remaining codes are ignored
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK      = 3'd0,
        OP_QUERY     = 3'd1,
        OP_CLEAR_ALL = 3'd2,
        OP_CLEAR_OTH = 3'd3,
        OP_ACT_EVENT = 3'd4,
        OP_ACT_READ  = 3'd5
    } t_opcode;

    // Query answers
    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG  = 2'd2
    } t_press_class;

    // Register indexes, taken from the word address
    typedef enum logic [0:0] {
        REG_LONG_THR  = 1'b0,
        REG_SHORT_THR = 1'b1
    } t_reg_index;

    // One input transaction
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PIN_W-1:0]    pins;
        logic [IDX_W-1:0]    idx;
    } t_item;

    // One result transaction
    typedef struct packed {
        t_press_class press_class;
        logic         activity_flag;
    } t_result;

    // Only a query and a read of the activity flag give a result
    function automatic logic has_result(input logic [OPCODE_W-1:0] op);
        return (op == OP_QUERY) || (op == OP_ACT_READ);
    endfunction

endpackage

// File: rtl/bpc_cfg.sv
// Threshold registers behind the APB-style configuration port.
module bpc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [bpc_pkg::THR_W-1:0]    o_long_thr,
    output logic [bpc_pkg::THR_W-1:0]    o_short_thr
);

    logic [bpc_pkg::THR_W-1:0] r_long_thr;
    logic [bpc_pkg::THR_W-1:0] r_short_thr;
    logic                      wr_en;
    bpc_pkg::t_reg_index       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = bpc_pkg::t_reg_index'(paddr[2]);

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_thr  <= bpc_pkg::LONG_THR_RST;
            r_short_thr <= bpc_pkg::SHORT_THR_RST;
        end else if (wr_en) begin
            case (reg_sel)
                bpc_pkg::REG_LONG_THR:  r_long_thr  <= pwdata[bpc_pkg::THR_W-1:0];
                bpc_pkg::REG_SHORT_THR: r_short_thr <= pwdata[bpc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed threshold
    always_comb begin
        case (reg_sel)
            bpc_pkg::REG_LONG_THR:  prdata = bpc_pkg::DATA_W'(r_long_thr);
            bpc_pkg::REG_SHORT_THR: prdata = bpc_pkg::DATA_W'(r_short_thr);
            default:                prdata = '0;
        endcase
    end

    assign o_long_thr  = r_long_thr;
    assign o_short_thr = r_short_thr;

endmodule

// File: rtl/bpc_core.sv
// Per-button state, tick update and press classification for one transaction.
module bpc_core #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_BITS  = bpc_pkg::COUNT_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  bpc_pkg::t_item             i_item,
    input  logic [bpc_pkg::THR_W-1:0]  i_long_thr,
    input  logic [bpc_pkg::THR_W-1:0]  i_short_thr,
    output bpc_pkg::t_result           o_result
);

    // Pin vector wide enough to index every button
    localparam int PX_W  = (NUM_BUTTONS > bpc_pkg::PIN_W + 1) ? NUM_BUTTONS
                                                              : bpc_pkg::PIN_W + 1;
    localparam int CMP_W = (COUNT_BITS > bpc_pkg::THR_W) ? COUNT_BITS : bpc_pkg::THR_W;

    logic [NUM_BUTTONS-1:0]                 r_flags;
    logic [NUM_BUTTONS-1:0]                 n_flags;
    logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0] r_counts;
    logic [NUM_BUTTONS-1:0][COUNT_BITS-1:0] n_counts;
    logic                                   r_activity;
    logic                                   n_activity;
    logic [PX_W-1:0]                        pins_ext;
    logic [PX_W-1:0]                        pin_mask;
    logic [NUM_BUTTONS-1:0]                 gt_long;
    logic [NUM_BUTTONS-1:0]                 gt_short;
    logic [NUM_BUTTONS-1:0]                 sel;
    bpc_pkg::t_result                       result;

    // Button k sits on pin bit k-1; button 0 and those above the pins have none
    assign pins_ext = PX_W'({i_item.pins, 1'b0});
    assign pin_mask = PX_W'({{bpc_pkg::PIN_W{1'b1}}, 1'b0});

    // Compare every count against both thresholds, and decode the index
    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            gt_long[b]  = CMP_W'(r_counts[b]) > CMP_W'(i_long_thr);
            gt_short[b] = CMP_W'(r_counts[b]) > CMP_W'(i_short_thr);
            sel[b]      = int'(i_item.idx) == b;
        end
    end

    // Work out the next state and the result
    always_comb begin
        n_flags    = r_flags;
        n_counts   = r_counts;
        n_activity = r_activity;
        result     = '{press_class: bpc_pkg::CLS_NONE, activity_flag: 1'b0};
        case (i_item.opcode)
            bpc_pkg::OP_TICK: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (pin_mask[b]) begin
                        if (pins_ext[b]) begin
                            if (!r_flags[b]) begin
                                n_flags[b]  = 1'b1;
                                n_counts[b] = COUNT_BITS'(1);
                            end else if (!(&r_counts[b])) begin
                                n_counts[b] = r_counts[b] + COUNT_BITS'(1);
                            end
                        end else begin
                            n_flags[b] = 1'b0;
                        end
                    end
                end
            end
            bpc_pkg::OP_QUERY: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (sel[b]) begin
                        if (r_flags[b]) begin
                            if (gt_long[b]) result.press_class = bpc_pkg::CLS_LONG;
                        end else begin
                            if (gt_short[b]) result.press_class = bpc_pkg::CLS_SHORT;
                            n_counts[b] = '0;
                        end
                    end
                end
            end
            bpc_pkg::OP_CLEAR_ALL: begin
                n_flags    = '0;
                n_counts   = '0;
                n_activity = 1'b0;
            end
            bpc_pkg::OP_CLEAR_OTH: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (!sel[b]) begin
                        n_flags[b]  = 1'b0;
                        n_counts[b] = '0;
                    end
                end
            end
            bpc_pkg::OP_ACT_EVENT: begin
                n_activity = 1'b1;
            end
            bpc_pkg::OP_ACT_READ: begin
                result.activity_flag = r_activity;
                n_activity           = 1'b0;
            end
            default: ;
        endcase
    end

    // Commit the state when the transaction executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags    <= '0;
            r_counts   <= '0;
            r_activity <= 1'b0;
        end else if (i_fire) begin
            r_flags    <= n_flags;
            r_counts   <= n_counts;
            r_activity <= n_activity;
        end
    end

    assign o_result = result;

endmodule

// File: rtl/button_press_classifier.sv
// Top level of the button press classifier: input stage, core and result stage.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_opcode, i_pin_levels, i_button_index
//  out      from block o_out_valid / i_out_stall o_press_class, o_activity_flag
//  cfg      to block   psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One transaction a cycle while neither channel stalls: an accepted item is held in the input
// register, executes against the button state, and a query or activity read lands in the
// result register; the input register can take a new item in the cycle its item executes.
// Reset is synchronous, clears the state and both stage valids, and restores the reset thresholds.
// A stalled result only holds back items that give a result; ticks and clears keep flowing.
module button_press_classifier #(
    parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
    parameter int COUNT_BITS  = bpc_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [bpc_pkg::OPCODE_W-1:0]    i_opcode,
    input  logic [bpc_pkg::PIN_W-1:0]       i_pin_levels,
    input  logic [bpc_pkg::IDX_W-1:0]       i_button_index,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bpc_pkg::CLASS_W-1:0]     o_press_class,
    output logic                            o_activity_flag,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]      paddr,
    input  logic [bpc_pkg::DATA_W-1:0]      pwdata,
    output logic [bpc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    logic                      r_in_valid;
    bpc_pkg::t_item            r_in_item;
    logic                      r_out_valid;
    bpc_pkg::t_result          r_out_result;
    logic                      in_accept;
    logic                      out_free;
    logic                      gives_result;
    logic                      fire;
    logic [bpc_pkg::THR_W-1:0] long_thr;
    logic [bpc_pkg::THR_W-1:0] short_thr;
    bpc_pkg::t_result          core_result;

    // Threshold registers
    bpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_long_thr  (long_thr),
        .o_short_thr (short_thr)
    );

    // Execute when the result slot can take what the item gives
    assign out_free     = !r_out_valid || !i_out_stall;
    assign gives_result = bpc_pkg::has_result(r_in_item.opcode);
    assign fire         = r_in_valid && (!gives_result || out_free);
    assign o_in_stall   = r_in_valid && !fire;
    assign in_accept    = i_in_valid && !o_in_stall;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= '{opcode: i_opcode, pins: i_pin_levels, idx: i_button_index};
        end
    end

    // Button state and classification
    bpc_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in_item),
        .i_long_thr  (long_thr),
        .i_short_thr (short_thr),
        .o_result    (core_result)
    );

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && gives_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && gives_result) begin
            r_out_result <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_press_class   = r_out_result.press_class;
    assign o_activity_flag = r_out_result.activity_flag;

    // Only a waiting item may hold off new transactions
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input stage");

    // A result answers a query or an activity read, never both
    a_single_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_activity_flag && (o_press_class != bpc_pkg::CLS_NONE)))
        else $error("result carries both a press class and an activity flag");

    // An item without a result leaves the drained result stage empty
    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !gives_result && out_free) |=> !o_out_valid)
        else $error("result appeared for an item that gives none");

    // An item that gives a result never executes over a stalled result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_in_valid && gives_result) |-> !fire)
        else $error("stalled result overwritten");

endmodule

// File: tb/sv/tb_button_press_classifier.sv
// Self-checking testbench for the button press classifier: directed, threshold, stall and random traffic.
module tb_button_press_classifier;
    import bpc_pkg::*;

    localparam int NUM_BUTTONS   = NUM_BUTTONS_DEF;
    localparam int COUNT_BITS    = COUNT_BITS_DEF;
    localparam int PIN_BUTTONS   = 4;
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 5000;
    localparam int MAX_REPORTS   = 30;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic [OPCODE_W-1:0] i_opcode       = '0;
    logic [PIN_W-1:0]    i_pin_levels   = '0;
    logic [IDX_W-1:0]    i_button_index = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [CLASS_W-1:0]  o_press_class;
    logic                o_activity_flag;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predicted button state and thresholds
    logic                  btn_pressed [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] btn_ticks   [NUM_BUTTONS];
    logic                  activity_pending;
    logic [THR_W-1:0]      long_limit;
    logic [THR_W-1:0]      short_limit;

    t_result pending_answers[$];

    int items_sent      = 0;
    int results_checked = 0;
    int error_count     = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_left       = 0;

    button_press_classifier #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .COUNT_BITS  (COUNT_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_pin_levels    (i_pin_levels),
        .i_button_index  (i_button_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_press_class   (o_press_class),
        .o_activity_flag (o_activity_flag),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #1 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("MISMATCH %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Clear every button, the activity flag and restore the thresholds
    task automatic reset_button_model();
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            btn_pressed[b] = 1'b0;
            btn_ticks[b]   = '0;
        end
        activity_pending = 1'b0;
        long_limit       = LONG_THR_RST;
        short_limit      = SHORT_THR_RST;
    endtask

    // Advance the button state by one transaction and queue any answer
    task automatic apply_button_item(input logic [OPCODE_W-1:0] op,
                                     input logic [PIN_W-1:0] pins,
                                     input logic [IDX_W-1:0] idx);
        t_result ans;
        ans.press_class   = CLS_NONE;
        ans.activity_flag = 1'b0;
        case (op)
            OP_TICK: begin
                for (int b = 1; b < NUM_BUTTONS && b <= PIN_BUTTONS; b++) begin
                    if (pins[b-1]) begin
                        if (!btn_pressed[b]) begin
                            btn_pressed[b] = 1'b1;
                            btn_ticks[b]   = '0;
                        end
                        if (btn_ticks[b] != '1) btn_ticks[b]++;
                    end else begin
                        btn_pressed[b] = 1'b0;
                    end
                end
            end
            OP_QUERY: begin
                if (idx < NUM_BUTTONS) begin
                    if (btn_pressed[idx]) begin
                        if (btn_ticks[idx] > long_limit) ans.press_class = CLS_LONG;
                    end else begin
                        if (btn_ticks[idx] > short_limit) ans.press_class = CLS_SHORT;
                        btn_ticks[idx] = '0;
                    end
                end
                pending_answers.push_back(ans);
            end
            OP_CLEAR_ALL: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    btn_pressed[b] = 1'b0;
                    btn_ticks[b]   = '0;
                end
                activity_pending = 1'b0;
            end
            OP_CLEAR_OTH: begin
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    if (b != idx) begin
                        btn_pressed[b] = 1'b0;
                        btn_ticks[b]   = '0;
                    end
                end
            end
            OP_ACT_EVENT: begin
                activity_pending = 1'b1;
            end
            OP_ACT_READ: begin
                ans.activity_flag = activity_pending;
                activity_pending  = 1'b0;
                pending_answers.push_back(ans);
            end
            default: begin
            end
        endcase
    endtask

    // Offer one transaction, hold it until accepted, then predict it
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [PIN_W-1:0] pins,
                             input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_pin_levels   <= pins;
        i_button_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_button_item(op, pins, idx);
        if (op <= OP_ACT_READ) items_sent++;
    endtask

    // Drop valid and wait until every answer is back and the pipeline is empty
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one threshold register over the configuration port while idle
    task automatic write_threshold(input t_reg_index idx, input logic [THR_W-1:0] value);
        logic [DATA_W-THR_W-1:0] junk;
        junk = (DATA_W-THR_W)'($urandom);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_LONG_THR) begin
            long_limit = value;
        end else begin
            short_limit = value;
        end
    endtask

    // Field extremes, every operation and the out-of-range cases
    task automatic test_directed_basics();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(REG_LONG_THR, 16'd2);
        write_threshold(REG_SHORT_THR, 16'd1);
        send_item(OP_ACT_READ, '0, '0);
        send_item(OP_ACT_EVENT, '0, '0);
        send_item(OP_ACT_READ, '0, '0);
        send_item(OP_ACT_READ, '0, '0);
        repeat (3) send_item(OP_TICK, 4'hF, '0);
        send_item(OP_QUERY, '0, 3'd1);
        send_item(OP_QUERY, '0, 3'd0);
        send_item(OP_QUERY, '0, 3'd4);
        send_item(OP_TICK, 4'h5, 3'd7);
        send_item(OP_QUERY, '0, 3'd2);
        send_item(OP_QUERY, '0, 3'd2);
        send_item(OP_QUERY, 4'hF, 3'd5);
        send_item(OP_QUERY, '0, 3'd7);
        send_item(OP_CLEAR_OTH, '0, 3'd1);
        send_item(OP_QUERY, '0, 3'd3);
        send_item(OP_QUERY, '0, 3'd1);
        send_item(OP_CLEAR_OTH, '0, 3'd6);
        send_item(OP_QUERY, '0, 3'd1);
        send_item(OP_TICK, 4'h1, '0);
        send_item(OP_TICK, 4'h0, '0);
        send_item(OP_QUERY, '0, 3'd1);
        send_item(OP_ACT_EVENT, '0, '0);
        send_item(OP_CLEAR_ALL, '0, '0);
        send_item(OP_ACT_READ, '0, '0);
        send_item(3'd6, 4'hF, 3'd7);
        send_item(3'd7, 4'hA, 3'd2);
        send_item(OP_ACT_READ, '0, '0);
        wait_drain();
    endtask

    // Zero thresholds: any press classifies
    task automatic test_threshold_extremes();
        write_threshold(REG_LONG_THR, 16'd0);
        write_threshold(REG_SHORT_THR, 16'd0);
        send_item(OP_CLEAR_ALL, '0, '0);
        send_item(OP_TICK, 4'h2, '0);
        send_item(OP_QUERY, '0, 3'd2);
        send_item(OP_QUERY, '0, 3'd3);
        send_item(OP_TICK, 4'h0, '0);
        send_item(OP_QUERY, '0, 3'd2);
        send_item(OP_QUERY, '0, 3'd2);
        wait_drain();
    endtask

    // Hold off the result side for a long stretch so the input backs up
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drain();
        @(negedge i_clk);
        hold_left = 60;
        @(posedge i_clk);
        for (int i = 0; i < 40; i++) begin
            if (i % 3 == 0) begin
                send_item(OP_TICK, 4'($urandom), '0);
            end else begin
                send_item(OP_QUERY, '0, 3'($urandom_range(4)));
            end
        end
        wait_drain();
        send_item(OP_ACT_EVENT, '0, '0);
        send_item(OP_ACT_READ, '0, '0);
        wait_drain();
    endtask

    // Mostly press gestures with random content, the rest random transactions
    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input logic [THR_W-1:0] long_v,
                                       input logic [THR_W-1:0] short_v, input int quota);
        int goal;
        int b;
        int hold;
        logic [PIN_W-1:0] mask;
        write_threshold(REG_LONG_THR, long_v);
        write_threshold(REG_SHORT_THR, short_v);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = items_sent + quota;
        while (items_sent < goal) begin
            if ($urandom_range(99) < 65) begin
                b    = $urandom_range(PIN_BUTTONS, 1);
                mask = PIN_W'(1 << (b - 1));
                hold = ($urandom_range(24) == 0) ? $urandom_range(110, 20)
                                                 : $urandom_range(12, 1);
                for (int i = 0; i < hold; i++) begin
                    if ($urandom_range(9) == 0) send_item(OP_QUERY, 4'($urandom), 3'(b));
                    send_item(OP_TICK, 4'($urandom) | mask, 3'($urandom));
                end
                send_item(OP_TICK, 4'($urandom) & ~mask, 3'($urandom));
                if ($urandom_range(4) == 0) begin
                    send_item(OP_QUERY, 4'($urandom), 3'($urandom));
                end else begin
                    send_item(OP_QUERY, 4'($urandom), 3'(b));
                end
            end else begin
                send_item(3'($urandom), 4'($urandom), 3'($urandom));
            end
        end
        wait_drain();
    endtask

    // Drive the result-side stall: long hold first, else random idling
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected result, press_class", 0, 32'(o_press_class));
            end else begin
                want = pending_answers.pop_front();
                results_checked++;
                if (o_press_class !== want.press_class) begin
                    report_mismatch("press_class", 32'(want.press_class),
                                    32'(o_press_class));
                end
                if (o_activity_flag !== want.activity_flag) begin
                    report_mismatch("activity_flag", 32'(want.activity_flag),
                                    32'(o_activity_flag));
                end
            end
        end
    end

    // End the run if nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (psel && penable && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Sequence the tests
    initial begin
        reset_button_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_basics();
        test_threshold_extremes();
        test_output_backpressure();
        test_random_traffic(19, 83, 16'd6, 16'd3, 155);
        test_random_traffic(83, 19, 16'd12, 16'd2, 155);
        test_random_traffic(0, 0, LONG_THR_RST, SHORT_THR_RST, 160);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_answers.size() != 0) begin
            report_mismatch("results still outstanding", 0, pending_answers.size());
        end
        $display("Run covered %0d transactions: every opcode, threshold extremes,",
                 items_sent);
        $display("a long result stall and three idling mixes; %0d results checked, %0d errors",
                 results_checked, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
